/* hw/rtl/bmp_texture_load_and_sample_macros.svh */
// Assertion macros used by the checker of the BMP texture loader and sampler.
`ifndef BMP_TEXTURE_LOAD_AND_SAMPLE_MACROS_SVH
`define BMP_TEXTURE_LOAD_AND_SAMPLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/btls_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and codes of the BMP texture loader and sampler.
package btls_pkg;

  // Texture limits and header layout.
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int HEADER_BYTES = 30;
  localparam int OFS_POS      = 10;
  localparam int WID_POS      = 18;
  localparam int HGT_POS      = 22;
  localparam int BPP_POS      = 28;

  // Derived widths.
  localparam int DIMW_W    = $clog2(MAX_WIDTH + 1);
  localparam int DIMH_W    = $clog2(MAX_HEIGHT + 1);
  localparam int XI_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YI_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int TEX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
  localparam int RS_W      = $clog2(4 * MAX_WIDTH + 1);
  localparam int RBI_W     = $clog2(4 * MAX_WIDTH);
  localparam int PROD_W    = DIMH_W + RS_W;
  localparam int COORD_W   = 20;
  localparam int FRAC_W    = 16;
  localparam int TEXEL_W   = 24;

  // Accepted pixel depths.
  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;

  // Request and result kinds.
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_SAMPLE  = 1'b1;
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SHORT  = 3'd1;
  localparam logic [2:0] ST_ZERO   = 3'd2;
  localparam logic [2:0] ST_LARGE  = 3'd3;
  localparam logic [2:0] ST_UNSUP  = 3'd4;
  localparam logic [2:0] ST_NOTEX  = 3'd5;

  // Input item.
  typedef struct packed {
    logic                      req_type;
    logic [7:0]                file_byte;
    logic                      last_byte;
    logic signed [COORD_W-1:0] coord_u;
    logic signed [COORD_W-1:0] coord_v;
  } btls_in_t;

  // Result item.
  typedef struct packed {
    logic       result_kind;
    logic [2:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } btls_out_t;

  // Texel write request from the loader.
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [TEXEL_W-1:0] data;
  } btls_wr_t;

  // Geometry and state of the loaded texture.
  typedef struct packed {
    logic              valid;
    logic [DIMW_W-1:0] width;
    logic [DIMH_W-1:0] height;
  } btls_tex_t;

endpackage

/* hw/rtl/btls_texmem.sv */
`timescale 1ns / 1ps
// Texel memory: one write port and one read port with registered read data.
module btls_texmem
  import btls_pkg::*;
(
  input  logic               clk,
  input  btls_wr_t           wr,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [TEXEL_W-1:0] rd_data
);

  logic [TEXEL_W-1:0] mem [TEX_DEPTH];
  logic [TEXEL_W-1:0] rd_data_r;

  // Write port, driven by the loader.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, driven by the sampler.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/btls_loader.sv */
`timescale 1ns / 1ps
// File byte parser: header fields, pixel packing, texel writes and load status.
module btls_loader
  import btls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_fire,
  input  logic [7:0] file_byte,
  input  logic       last_byte,
  output btls_wr_t   wr,
  output logic [2:0] report_status,
  output btls_tex_t  tex
);

  logic [31:0]       pos_r, pos_nxt;
  logic [31:0]       offset_r, offset_nxt;
  logic [31:0]       width_r, width_nxt;
  logic [31:0]       height_r, height_nxt;
  logic [15:0]       bpp_r, bpp_nxt;
  logic [RBI_W-1:0]  rbi_r, rbi_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic [DIMW_W-1:0] pix_r, pix_nxt;
  logic [DIMH_W-1:0] row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [15:0]       pp_r, pp_nxt;
  logic [2:0]        err_r, err_nxt;
  logic              valid_r, valid_nxt;
  logic [PROD_W-1:0] prod_r;

  logic [DIMW_W-1:0] w;
  logic [DIMH_W-1:0] h;
  logic              bpp32;
  logic [RS_W-1:0]   w3;
  logic [RS_W-1:0]   rs;
  logic [RS_W-1:0]   rbi_inc;
  logic [1:0]        last_comp;
  logic              far;
  logic [32:0]       need;
  logic [1:0]        lane_ofs, lane_wid, lane_hgt;
  logic              lane_bpp;
  logic [2:0]        st;

  // Geometry of the current file, meaningful once the header has passed.
  assign w         = width_r[DIMW_W-1:0];
  assign h         = height_r[DIMH_W-1:0];
  assign bpp32     = (bpp_r == BPP_32);
  assign w3        = RS_W'(w) + RS_W'({w, 1'b0});
  assign rs        = bpp32 ? RS_W'({w, 2'b00}) : ((w3 + RS_W'(3)) & ~RS_W'(3));
  assign rbi_inc   = RS_W'(rbi_r) + RS_W'(1);
  assign last_comp = bpp32 ? 2'd3 : 2'd2;

  // Required file length overflows the saturating byte counter.
  assign need = {1'b0, offset_r} + 33'(prod_r);
  assign far  = need[32];

  // Byte lanes of the little-endian header fields.
  assign lane_ofs = pos_r[1:0] - 2'(OFS_POS);
  assign lane_wid = pos_r[1:0] - 2'(WID_POS);
  assign lane_hgt = pos_r[1:0] - 2'(HGT_POS);
  assign lane_bpp = pos_r[0] - 1'(BPP_POS);

  // Per-byte update of the parse state.
  always_comb begin
    pos_nxt       = pos_r;
    offset_nxt    = offset_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    bpp_nxt       = bpp_r;
    rbi_nxt       = rbi_r;
    comp_nxt      = comp_r;
    pix_nxt       = pix_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    pp_nxt        = pp_r;
    err_nxt       = err_r;
    valid_nxt     = valid_r;
    wr            = '0;
    st            = ST_OK;
    report_status = ST_OK;

    if (byte_fire) begin
      // The first byte of a file drops everything from the previous one.
      if (pos_r == '0) begin
        offset_nxt = '0;
        width_nxt  = '0;
        height_nxt = '0;
        bpp_nxt    = '0;
        rbi_nxt    = '0;
        comp_nxt   = '0;
        pix_nxt    = '0;
        row_nxt    = '0;
        base_nxt   = '0;
        pp_nxt     = '0;
        err_nxt    = ST_OK;
        valid_nxt  = 1'b0;
      end

      if (pos_r < 32'(HEADER_BYTES)) begin
        // Header bytes fill their field lanes.
        if (pos_r >= 32'(OFS_POS) && pos_r <= 32'(OFS_POS + 3)) begin
          offset_nxt[{lane_ofs, 3'b000} +: 8] = file_byte;
        end else if (pos_r >= 32'(WID_POS) && pos_r <= 32'(WID_POS + 3)) begin
          width_nxt[{lane_wid, 3'b000} +: 8] = file_byte;
        end else if (pos_r >= 32'(HGT_POS) && pos_r <= 32'(HGT_POS + 3)) begin
          height_nxt[{lane_hgt, 3'b000} +: 8] = file_byte;
        end else if (pos_r >= 32'(BPP_POS) && pos_r <= 32'(BPP_POS + 1)) begin
          bpp_nxt[{lane_bpp, 3'b000} +: 8] = file_byte;
        end
        // The last header byte settles the header check.
        if (pos_r == 32'(HEADER_BYTES - 1)) begin
          if (width_nxt == '0 || height_nxt == '0) begin
            err_nxt = ST_ZERO;
          end else if ((bpp_nxt != BPP_24 && bpp_nxt != BPP_32) ||
                       offset_nxt < 32'(HEADER_BYTES)) begin
            err_nxt = ST_UNSUP;
          end else if (width_nxt > 32'(MAX_WIDTH) || height_nxt > 32'(MAX_HEIGHT)) begin
            err_nxt = ST_LARGE;
          end else begin
            err_nxt = ST_OK;
          end
        end
      end else if (err_r == ST_OK && pos_r >= offset_r && row_r < h) begin
        // Pixel bytes: blue and green wait, red completes the texel.
        if (pix_r < w) begin
          case (comp_r)
            2'd0: begin
              pp_nxt[7:0] = file_byte;
            end
            2'd1: begin
              pp_nxt[15:8] = file_byte;
            end
            2'd2: begin
              wr.en   = 1'b1;
              wr.addr = ADDR_W'(base_r + ADDR_W'(pix_r));
              wr.data = {file_byte, pp_r};
            end
            default: begin
              // Alpha byte of a 32-bit pixel is dropped.
            end
          endcase
          if (comp_r == last_comp) begin
            comp_nxt = '0;
            pix_nxt  = pix_r + DIMW_W'(1);
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
        // End of the padded row.
        if (rbi_inc >= rs) begin
          rbi_nxt  = '0;
          comp_nxt = '0;
          pix_nxt  = '0;
          row_nxt  = row_r + DIMH_W'(1);
          base_nxt = base_r + ADDR_W'(w);
        end else begin
          rbi_nxt = rbi_inc[RBI_W-1:0];
        end
      end

      // The byte counter saturates on very long files.
      if (pos_r != '1) begin
        pos_nxt = pos_r + 32'd1;
      end

      // Final status of the load.
      if (last_byte) begin
        if (pos_r < 32'(HEADER_BYTES - 1)) begin
          st = ST_SHORT;
        end else if (err_nxt != ST_OK) begin
          st = err_nxt;
        end else if (row_nxt < h || far) begin
          st = ST_SHORT;
        end else begin
          st = ST_OK;
        end
        report_status = st;
        err_nxt       = st;
        valid_nxt     = (st == ST_OK);
        pos_nxt       = '0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      bpp_r    <= '0;
      rbi_r    <= '0;
      comp_r   <= '0;
      pix_r    <= '0;
      row_r    <= '0;
      base_r   <= '0;
      err_r    <= ST_OK;
      valid_r  <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_r    <= bpp_nxt;
      rbi_r    <= rbi_nxt;
      comp_r   <= comp_nxt;
      pix_r    <= pix_nxt;
      row_r    <= row_nxt;
      base_r   <= base_nxt;
      err_r    <= err_nxt;
      valid_r  <= valid_nxt;
    end
  end

  // Partial pixel and the image size product, which follows the header registers.
  always_ff @(posedge clk) begin
    pp_r   <= pp_nxt;
    prod_r <= PROD_W'(h) * PROD_W'(rs);
  end

  assign tex.valid  = valid_r;
  assign tex.width  = w;
  assign tex.height = h;

endmodule

/* hw/rtl/btls_sampler.sv */
`timescale 1ns / 1ps
// Nearest-texel address generator: scale, clamp, flip v, form the row-major address.
module btls_sampler
  import btls_pkg::*;
(
  input  logic                      clk,
  input  logic                      fire,
  input  logic signed [COORD_W-1:0] coord_u,
  input  logic signed [COORD_W-1:0] coord_v,
  input  btls_tex_t                 tex,
  output logic [ADDR_W-1:0]         rd_addr
);

  localparam int UP_W = COORD_W - 1 + DIMW_W;
  localparam int VP_W = COORD_W - 1 + DIMH_W;
  localparam int UT_W = UP_W - FRAC_W;
  localparam int VT_W = VP_W - FRAC_W;

  logic [UP_W-1:0] u_prod;
  logic [VP_W-1:0] v_prod;
  logic [UT_W-1:0] u_t;
  logic [VT_W-1:0] v_t;
  logic [XI_W-1:0] x_nxt, x_r;
  logic [YI_W-1:0] y_nxt, yf_r;

  // Scale the coordinates by the texture size and drop the fraction.
  assign u_prod = UP_W'(coord_u[COORD_W-2:0]) * UP_W'(tex.width);
  assign v_prod = VP_W'(coord_v[COORD_W-2:0]) * VP_W'(tex.height);
  assign u_t    = u_prod[UP_W-1:FRAC_W];
  assign v_t    = v_prod[VP_W-1:FRAC_W];

  // Clamp to the texture: negative to zero, past the edge to the last texel.
  always_comb begin
    if (coord_u[COORD_W-1]) begin
      x_nxt = '0;
    end else if (u_t >= UT_W'(tex.width)) begin
      x_nxt = XI_W'(tex.width - DIMW_W'(1));
    end else begin
      x_nxt = XI_W'(u_t);
    end
    if (coord_v[COORD_W-1]) begin
      y_nxt = '0;
    end else if (v_t >= VT_W'(tex.height)) begin
      y_nxt = YI_W'(tex.height - DIMH_W'(1));
    end else begin
      y_nxt = YI_W'(v_t);
    end
  end

  // Texel coordinates, with v flipped since rows are stored bottom-up.
  always_ff @(posedge clk) begin
    if (fire) begin
      x_r  <= x_nxt;
      yf_r <= YI_W'(tex.height - DIMH_W'(1) - DIMH_W'(y_nxt));
    end
  end

  assign rd_addr = ADDR_W'(ADDR_W'(yf_r) * ADDR_W'(tex.width) + ADDR_W'(x_r));

endmodule

/* hw/rtl/bmp_texture_load_and_sample.sv */
`timescale 1ns / 1ps
// Top level of the BMP texture loader and nearest-texel sampler.
//
// Input channel (in_valid, in_stall, in_item): each item is either one byte
// of a 24- or 32-bit BMP file, with last_byte marking the end of the file, or
// a sample request with signed u and v in fixed point with 16 fraction bits.
// Result channel (out_valid, out_stall, out_item): a load report for every
// file byte marked last, and one result for every sample request.
// A file byte is parsed as it is accepted; the load report appears the cycle after the
// last byte is accepted. A sample on a loaded texture passes through coordinate
// scaling, the registered read of the texel memory and the output load; no new
// item is accepted meanwhile. A sample with no texture loaded is answered the
// cycle after it is accepted with the no-texture status.
// Reset clears the parser and invalidates the texture; texel memory is not
// cleared, as it is read only after a complete load.
// While the receiver stalls a pending result, file bytes that produce no
// report are still accepted; items that would produce a result wait.
module bmp_texture_load_and_sample
  import btls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  btls_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output btls_out_t out_item
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_READ = 2'd1;
  localparam logic [1:0] PH_OUT  = 2'd2;

  logic [1:0]         phase_r, phase_nxt;
  logic               out_valid_r, out_valid_nxt;
  btls_out_t          out_item_r, out_item_nxt;
  logic               accept;
  logic               byte_fire;
  logic               smp_fire;
  logic               rd_en;
  logic [2:0]         report_status;
  logic [ADDR_W-1:0]  rd_addr;
  logic [TEXEL_W-1:0] rd_data;
  btls_wr_t           wr;
  btls_tex_t          tex;

  // Hold off while a sample is in flight, or when a result-producing item
  // meets a stalled output register.
  assign in_stall  = (phase_r != PH_IDLE) ||
                     (out_valid_r && out_stall && (in_item.req_type || in_item.last_byte));
  assign accept    = in_valid && !in_stall;
  assign byte_fire = accept && (in_item.req_type == REQ_BYTE);
  assign smp_fire  = accept && (in_item.req_type == REQ_SAMPLE);
  assign rd_en     = (phase_r == PH_READ);

  btls_loader u_loader (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_fire     (byte_fire),
    .file_byte     (in_item.file_byte),
    .last_byte     (in_item.last_byte),
    .wr            (wr),
    .report_status (report_status),
    .tex           (tex)
  );

  btls_sampler u_sampler (
    .clk     (clk),
    .fire    (smp_fire),
    .coord_u (in_item.coord_u),
    .coord_v (in_item.coord_v),
    .tex     (tex),
    .rd_addr (rd_addr)
  );

  btls_texmem u_texmem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencing of samples and loading of the output register.
  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    case (phase_r)
      PH_IDLE: begin
        if (byte_fire && in_item.last_byte) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.result_kind = KIND_LOAD;
          out_item_nxt.status      = report_status;
          out_item_nxt.red         = 8'd0;
          out_item_nxt.green       = 8'd0;
          out_item_nxt.blue        = 8'd0;
        end else if (smp_fire) begin
          if (tex.valid) begin
            phase_nxt = PH_READ;
          end else begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.result_kind = KIND_SAMPLE;
            out_item_nxt.status      = ST_NOTEX;
            out_item_nxt.red         = 8'd0;
            out_item_nxt.green       = 8'd0;
            out_item_nxt.blue        = 8'd0;
          end
        end
      end
      PH_READ: begin
        phase_nxt = PH_OUT;
      end
      PH_OUT: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.result_kind = KIND_SAMPLE;
        out_item_nxt.status      = ST_OK;
        out_item_nxt.red         = rd_data[23:16];
        out_item_nxt.green       = rd_data[15:8];
        out_item_nxt.blue        = rd_data[7:0];
        phase_nxt                = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hw/rtl/btls_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the BMP texture loader and sampler, with its bind.
`include "bmp_texture_load_and_sample_macros.svh"
module btls_checker
  import btls_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input btls_in_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input btls_out_t out_item
);

  // A stalled result stays put.
  `BTLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_item), "stalled result changed")

  // A no-texture answer carries no color.
  `BTLS_ASSERT_NOW(a_notex_blank, out_valid && out_item.status == ST_NOTEX,
    out_item.result_kind == KIND_SAMPLE && out_item.red == 8'd0 &&
    out_item.green == 8'd0 && out_item.blue == 8'd0, "no-texture result not blank")

  // A load report carries no color and a load status.
  `BTLS_ASSERT_NOW(a_report_form, out_valid && out_item.result_kind == KIND_LOAD,
    out_item.red == 8'd0 && out_item.green == 8'd0 && out_item.blue == 8'd0 &&
    out_item.status < ST_NOTEX, "malformed load report")

  // A sample result is either a texel or the no-texture answer.
  `BTLS_ASSERT_NOW(a_sample_status, out_valid && out_item.result_kind == KIND_SAMPLE,
    out_item.status == ST_OK || out_item.status == ST_NOTEX, "bad sample status")

  // A file byte that does not end the file yields no result.
  `BTLS_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall &&
    in_item.req_type == REQ_BYTE && !in_item.last_byte && !out_valid,
    !out_valid, "result without cause")

endmodule

bind bmp_texture_load_and_sample btls_checker u_btls_checker (.*);
